### src/longest_prefix_route_table_unit_macros.svh
// Assertion macros used by the route table engine.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_UNIT_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LPRT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("route table assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("route table assertion failed");

`endif

### src/lprt_pkg.sv
// Shared types, constants and helpers of the longest prefix route table.
`timescale 1ns / 1ps

package lprt_pkg;

	// Default table depth and the fixed number of ports the design supports.
	localparam int DefEntries = 64;
	localparam int Ports = 16;

	// Reset value of the output port count register.
	localparam logic [4:0] NumOutputsReset = 5'd16;

	// Longest prefix length that a route can carry.
	localparam logic [5:0] MaxLen = 6'd32;

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_SET    = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_ROUTE  = 3'd4,
		ST_BAD_PORT  = 3'd5
	} status_t;

	// Engine states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// One table entry as stored in memory.
	typedef struct packed {
		logic        valid;
		logic [31:0] prefix;
		logic [5:0]  length;
		logic [31:0] gateway;
		logic [3:0]  port;
		logic [7:0]  hops;
	} entry_t;

	// One result as handed to the output channel.
	typedef struct packed {
		status_t     status;
		logic        hit;
		logic [3:0]  port;
		logic [31:0] gateway;
		logic [31:0] next_hop;
	} result_t;

	// Network mask for a prefix length; lengths of 32 or more give all ones.
	function automatic logic [31:0] len_mask(input logic [5:0] len);
		len_mask = ~(32'hFFFF_FFFF >> len);
	endfunction

endpackage

### src/lprt_table_mem.sv
// Route entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module lprt_table_mem import lprt_pkg::*; #(
	parameter int ENTRIES = DefEntries,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [ENTRIES];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered on re; the data appears in the cycle after the read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/lprt_engine.sv
// Scan engine: walks the table memory, tracks matches and commits changes.
`timescale 1ns / 1ps
`include "longest_prefix_route_table_unit_macros.svh"

module lprt_engine import lprt_pkg::*; #(
	parameter int ENTRIES = DefEntries,
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	// Request channel.
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	input  logic [31:0]   address,
	input  logic [5:0]    prefix_len,
	input  logic [31:0]   gateway,
	input  logic [3:0]    out_port,
	input  logic [7:0]    route_hops,
	// Configuration.
	input  logic [4:0]    num_outputs,
	// Result channel.
	output logic          out_valid,
	input  logic          out_ready,
	output result_t       res,
	// Table memory.
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output entry_t        mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  entry_t        mem_rdata
);

	state_t state_q, state_d;

	// Latched request.
	kind_t       kind_q;
	logic [31:0] addr_q;
	logic [31:0] prefix_q;
	logic [5:0]  plen_q;
	logic [31:0] gw_q;
	logic [3:0]  port_q;
	logic [7:0]  hops_q;
	logic        bad_q;

	// Scan pointer and read pipeline.
	logic [CW-1:0] rd_cnt_q;
	logic          chk_s1;
	logic [AW-1:0] idx_s1;

	// Match tracking.
	logic          best_found_q;
	logic [5:0]    best_len_q;
	logic [31:0]   best_gw_q;
	logic [3:0]    best_port_q;
	logic [7:0]    best_hops_q;
	logic          exact_found_q;
	logic [AW-1:0] exact_idx_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;

	// Output register.
	logic    out_valid_q;
	result_t res_q;

	// Commit decisions.
	result_t       commit_res;
	logic          commit_we;
	logic [AW-1:0] commit_addr;
	entry_t        commit_entry;
	logic          load_res;

	logic          accept;
	logic          bad_in;
	logic [5:0]    plen_sat;
	logic          scan_end;
	logic          lpm_hit;
	logic          exact_hit;

	assign accept   = in_valid && in_ready;
	assign plen_sat = (prefix_len > MaxLen) ? MaxLen : prefix_len;
	assign scan_end = (rd_cnt_q == CW'(ENTRIES)) && !chk_s1;

	// An add or set naming a port outside the configured range is rejected up front.
	assign bad_in = ((kind_t'(kind) == KIND_ADD) || (kind_t'(kind) == KIND_SET)) &&
		(({1'b0, out_port} >= num_outputs) || (32'(out_port) >= 32'(Ports)));

	// Request latch.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(kind);
			addr_q   <= address;
			plen_q   <= plen_sat;
			prefix_q <= address & len_mask(plen_sat);
			gw_q     <= gateway;
			port_q   <= out_port;
			hops_q   <= route_hops;
			bad_q    <= bad_in;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan pointer: sweeps the memory during the clearing pass and each scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			chk_s1   <= 1'b0;
		end else begin
			chk_s1 <= mem_re;
			if (accept) begin
				rd_cnt_q <= '0;
			end else if ((state_q == S_CLEAR) || mem_re) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[AW-1:0];
	end

	// Per-entry comparisons on the data returned by the memory.
	assign lpm_hit = mem_rdata.valid &&
		((addr_q & len_mask(mem_rdata.length)) == mem_rdata.prefix) &&
		(!best_found_q || (mem_rdata.length > best_len_q));
	assign exact_hit = mem_rdata.valid && !exact_found_q &&
		(mem_rdata.prefix == prefix_q) && (mem_rdata.length == plen_q);

	// Match tracking: longest match, first exact match and first free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q  <= 1'b0;
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (accept) begin
			best_found_q  <= 1'b0;
			exact_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (chk_s1) begin
			if (lpm_hit) begin
				best_found_q <= 1'b1;
			end
			if (exact_hit) begin
				exact_found_q <= 1'b1;
			end
			if (!mem_rdata.valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_s1) begin
			if (lpm_hit) begin
				best_len_q  <= mem_rdata.length;
				best_gw_q   <= mem_rdata.gateway;
				best_port_q <= mem_rdata.port;
				best_hops_q <= mem_rdata.hops;
			end
			if (exact_hit) begin
				exact_idx_q <= idx_s1;
			end
			if (!mem_rdata.valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// Result and table update chosen at the end of a scan.
	always_comb begin
		commit_res          = '0;
		commit_res.status   = ST_OK;
		commit_we           = 1'b0;
		commit_addr         = exact_idx_q;
		commit_entry.valid   = 1'b1;
		commit_entry.prefix  = prefix_q;
		commit_entry.length  = plen_q;
		commit_entry.gateway = gw_q;
		commit_entry.port    = port_q;
		commit_entry.hops    = hops_q;
		if (bad_q) begin
			commit_res.status = ST_BAD_PORT;
		end else begin
			unique case (kind_q)
				KIND_LOOKUP: begin
					if (best_found_q) begin
						commit_res.hit      = 1'b1;
						commit_res.port     = best_port_q;
						commit_res.gateway  = best_gw_q;
						commit_res.next_hop = ((best_gw_q != 32'd0) && (best_hops_q > 8'd1)) ?
							best_gw_q : addr_q;
					end else begin
						commit_res.status = ST_NO_ROUTE;
					end
				end
				KIND_REMOVE: begin
					commit_entry.valid = 1'b0;
					if (exact_found_q) begin
						commit_we = 1'b1;
					end else begin
						commit_res.status = ST_NOT_FOUND;
					end
				end
				KIND_ADD, KIND_SET: begin
					if (exact_found_q) begin
						if (kind_q == KIND_ADD) begin
							commit_res.status = ST_EXISTS;
						end else begin
							commit_we = 1'b1;
						end
					end else if (free_found_q) begin
						commit_we   = 1'b1;
						commit_addr = free_idx_q;
					end else begin
						commit_res.status = ST_FULL;
					end
				end
				default: begin
					commit_res.status = ST_OK;
				end
			endcase
		end
	end

	// Next state, memory control and handshake.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = rd_cnt_q[AW-1:0];
		mem_wdata = '0;
		load_res  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (rd_cnt_q == CW'(ENTRIES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bad_in ? S_COMMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				mem_re = (rd_cnt_q != CW'(ENTRIES));
				if (scan_end) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					load_res  = 1'b1;
					mem_we    = commit_we;
					mem_waddr = commit_addr;
					mem_wdata = commit_entry;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign mem_raddr = rd_cnt_q[AW-1:0];

	// Output register keeps the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= commit_res;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Reads and writes never share a cycle, so no entry is read while it changes.
	`LPRT_ASSERT_IMPLY(a_no_rw_overlap, clk, arst_n, mem_re, !mem_we)
	// An accepted request always starts a scan or goes straight to commit.
	`LPRT_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, (state_q == S_SCAN) || (state_q == S_COMMIT))
	// The read pipeline is empty by the time a request commits.
	`LPRT_ASSERT_IMPLY(a_commit_drained, clk, arst_n, state_q == S_COMMIT, !chk_s1 && !mem_re)

endmodule

### src/longest_prefix_route_table_unit.sv
// Top level of the longest prefix route table with its configuration port.
`timescale 1ns / 1ps

// Longest prefix route table. Requests (lookup, add, set, remove) are taken one
// at a time. After reset a clearing pass marks every entry free; in_ready stays
// low until it ends. Each request then scans the entry memory one entry per
// cycle through its single read port; an add or set with a bad port skips the
// scan and goes straight to commit. The result sits in an output register, and
// any table change is written back in the cycle that loads it.
// The num_outputs register lies at byte address 0 of the APB-style port.
module longest_prefix_route_table_unit import lprt_pkg::*; #(
	parameter int ENTRIES = DefEntries
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic [31:0] gateway,
	input  logic [3:0]  out_port,
	input  logic [7:0]  route_hops,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        hit,
	output logic [3:0]  route_port,
	output logic [31:0] route_gateway,
	output logic [31:0] next_hop
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [4:0]    num_outputs_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;
	result_t       res;
	logic          reg_sel;

	// Only register 0 exists; other word addresses read zero and ignore writes.
	assign reg_sel = (paddr[2] == 1'b0);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {27'd0, num_outputs_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_outputs_q <= NumOutputsReset;
		end else if (psel && penable && pwrite && reg_sel) begin
			num_outputs_q <= pwdata[4:0];
		end
	end

	lprt_table_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lprt_engine #(
		.ENTRIES(ENTRIES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.address     (address),
		.prefix_len  (prefix_len),
		.gateway     (gateway),
		.out_port    (out_port),
		.route_hops  (route_hops),
		.num_outputs (num_outputs_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// Unpack the result onto the output fields.
	assign status        = res.status;
	assign hit           = res.hit;
	assign route_port    = res.port;
	assign route_gateway = res.gateway;
	assign next_hop      = res.next_hop;

endmodule
